// ----- design/fbc_pkg.sv -----
// Shared types and constants for the Feistel block cipher.
package fbc_pkg;

   // Transaction field widths
   localparam int IDX_W      = 4;
   localparam int KEY_W      = 32;
   localparam int BLOCK_W    = 64;
   localparam int REQ_DATA_W = 104;  // key_index, key_value, block_in, zero fill
   localparam int RSP_DATA_W = 64;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 6;
   localparam int HALF_SEL_W  = 6;
   localparam int ROUND_CNT_W = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECRYPT     = 2'd2;

   localparam logic [HALF_SEL_W-1:0]  HALF_WIDTH_RESET  = 6'd32;
   localparam logic [ROUND_CNT_W-1:0] ROUND_COUNT_RESET = 5'd16;
   localparam logic [HALF_SEL_W-1:0]  HALF_GRID_MASK    = 6'h3C;
   localparam logic [HALF_SEL_W-1:0]  HALF_WIDTH_MIN    = 6'd4;

   // Request kinds carried on tuser
   localparam logic FUNC_LOAD_KEY = 1'b0;
   localparam logic FUNC_BLOCK    = 1'b1;

   // Controls from the sequencer to the round datapath
   typedef struct packed {
      logic load;  // capture halves of a new block
      logic step;  // apply one round with the key from memory
   } rnd_ctrl_type;

endpackage

// ----- design/fbc_key_mem.sv -----
// Round key memory: one write port, one registered read port.
module fbc_key_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/fbc_round_unit.sv -----
// Feistel round datapath: block split, one round per step, final pack.
module fbc_round_unit #(
   parameter int HALF_W = 32
) (
   input  logic                          clock,
   input  fbc_pkg::rnd_ctrl_type         ctrl,
   input  logic [fbc_pkg::HALF_SEL_W-1:0] half_sel,
   input  logic [fbc_pkg::BLOCK_W-1:0]   block_in,
   input  logic [HALF_W-1:0]             round_key,
   output logic [fbc_pkg::BLOCK_W-1:0]   block_out
);
   import fbc_pkg::*;

   logic [HALF_W-1:0] hmask;
   logic [HALF_W-1:0] left_ff, left_in;
   logic [HALF_W-1:0] right_ff, right_in;
   logic [BLOCK_W-1:0] upper;

   // Mask of the active half width; a shift by the full width clears the shifted ones, so the mask is all ones
   assign hmask = ~({HALF_W{1'b1}} << half_sel);
   assign upper = block_in >> half_sel;

   // Split on load, otherwise L' = R, R' = L ^ (K & ~R)
   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (ctrl.load) begin
         left_in  = upper[HALF_W-1:0] & hmask;
         right_in = block_in[HALF_W-1:0] & hmask;
      end else if (ctrl.step) begin
         left_in  = right_ff;
         right_in = (left_ff ^ (round_key & ~right_ff)) & hmask;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   // Final R above final L undoes the last swap
   assign block_out = (BLOCK_W'(right_ff) << half_sel) | BLOCK_W'(left_ff);

endmodule

// ----- design/feistel_block_cipher.sv -----
// Top level: configuration, round sequencer, key memory and output register.
// A key load transaction gives no response.
// A block transaction loads the round unit, runs one round per cycle in ST_RUN with keys
// from the key memory, where rounds is round_count capped at MAX_ROUNDS, then goes through
// ST_DONE into the output register; req_tready rises in the same cycle as rsp_tvalid, so a
// block is through before the next request is taken, longer while rsp_tready is low.
// Reset (synchronous) restores half_width 32, round_count 16, decrypt 0; keys are kept.
module feistel_block_cipher #(
   parameter int MAX_ROUNDS     = 16,
   parameter int MAX_HALF_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: key_index[3:0], key_value[35:4], block_in[99:36], zero fill
   input  logic [fbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: func (0 key load, 1 block)
   input  logic                            req_tuser,
   // Response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: block_out[63:0]
   output logic [fbc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration write port
   input  logic                            csr_wen,
   input  logic [fbc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fbc_pkg::*;

   localparam int ADDR_W = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Request fields
   logic [IDX_W-1:0]   key_index;
   logic [KEY_W-1:0]   key_value;
   logic [BLOCK_W-1:0] block_in;
   logic               req_accept;
   logic               is_block;

   // Configuration registers
   logic [HALF_SEL_W-1:0]  half_width_ff;
   logic [ROUND_CNT_W-1:0] round_count_ff;
   logic                   decrypt_ff;

   // Effective settings
   logic [HALF_SEL_W-1:0] half_grid;
   logic [HALF_SEL_W-1:0] half_sel;
   logic [CNT_W-1:0]      rounds_eff;

   // Sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] rnd_ff, rnd_in;
   logic [CNT_W-1:0] rnd_next;
   logic [CNT_W-1:0] rd_round;
   logic [CNT_W-1:0] rd_slot;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             out_free;

   // Memory and datapath connections
   logic                      mem_wr_en;
   logic [ADDR_W-1:0]         mem_wr_addr;
   logic                      mem_rd_en;
   logic [MAX_HALF_WIDTH-1:0] round_key;
   logic [BLOCK_W-1:0]        block_out;
   rnd_ctrl_type              rnd_ctrl;

   assign key_index = req_tdata[IDX_W-1:0];
   assign key_value = req_tdata[IDX_W+KEY_W-1:IDX_W];
   assign block_in  = req_tdata[IDX_W+KEY_W+BLOCK_W-1:IDX_W+KEY_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_block   = (req_tuser == FUNC_BLOCK);

   // Configuration writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= HALF_WIDTH_RESET;
         round_count_ff <= ROUND_COUNT_RESET;
         decrypt_ff     <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_HALF_WIDTH:  half_width_ff  <= csr_wdata;
            CSR_ROUND_COUNT: round_count_ff <= csr_wdata[ROUND_CNT_W-1:0];
            CSR_DECRYPT:     decrypt_ff     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Half width on the grid of four, clamped to the supported range
   assign half_grid = half_width_ff & HALF_GRID_MASK;
   always_comb begin
      priority if (half_grid < HALF_WIDTH_MIN) begin
         half_sel = HALF_WIDTH_MIN;
      end else if (32'(half_grid) > MAX_HALF_WIDTH) begin
         half_sel = HALF_SEL_W'(MAX_HALF_WIDTH);
      end else begin
         half_sel = half_grid;
      end
   end

   assign rounds_eff = (32'(round_count_ff) > MAX_ROUNDS) ? CNT_W'(MAX_ROUNDS)
                                                          : CNT_W'(round_count_ff);

   // Key slot for the round being fetched; reverse order when decrypting
   assign rnd_next = rnd_ff + CNT_W'(1);
   assign rd_round = (state_ff == ST_RUN) ? rnd_next : '0;
   assign rd_slot  = decrypt_ff ? (rounds_eff - CNT_W'(1) - rd_round) : rd_round;

   assign mem_wr_en   = req_accept && !is_block && (32'(key_index) < MAX_ROUNDS);
   assign mem_wr_addr = ADDR_W'(key_index);
   assign mem_rd_en   = (req_accept && is_block && (rounds_eff != '0)) ||
                        ((state_ff == ST_RUN) && (rnd_next < rounds_eff));

   assign rnd_ctrl.load = req_accept && is_block;
   assign rnd_ctrl.step = (state_ff == ST_RUN);

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer and output register
   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_block) begin
               rnd_in   = '0;
               state_in = (rounds_eff == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            rnd_in = rnd_next;
            if (rnd_next == rounds_eff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = block_out;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   fbc_key_mem #(
      .DEPTH  (MAX_ROUNDS),
      .ADDR_W (ADDR_W),
      .DATA_W (MAX_HALF_WIDTH)
   ) u_key_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (key_value[MAX_HALF_WIDTH-1:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_slot[ADDR_W-1:0]),
      .rd_data (round_key)
   );

   fbc_round_unit #(
      .HALF_W (MAX_HALF_WIDTH)
   ) u_round_unit (
      .clock     (clock),
      .ctrl      (rnd_ctrl),
      .half_sel  (half_sel),
      .block_in  (block_in),
      .round_key (round_key),
      .block_out (block_out)
   );

endmodule
